### design/esd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg: shared constants and helpers
// Calendar constants and the small arithmetic helpers used by the summer
// time pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  localparam int unsigned SecsW     = 32;
  localparam int unsigned DayW      = 16;
  localparam int unsigned YearW     = 12;
  localparam int unsigned OutDataW  = 80;

  localparam logic [SecsW-1:0] LAST_SECOND  = 32'd4102444799;
  localparam logic [16:0]      SECS_PER_DAY = 17'd86400;
  localparam logic [SecsW-1:0] START_SECS   = 32'd3600;
  localparam logic [SecsW-1:0] END_SECS     = 32'd3599;

  // floor(2^32 / 675): days estimate from seconds >> 7, low by at most one
  localparam logic [22:0] DAY_RECIP   = 23'd6362914;
  // floor(2^26 / 1461): four-year cycle estimate, low by at most one
  localparam logic [15:0] CYCLE_RECIP = 16'd45933;
  localparam int unsigned CycleShift  = 26;

  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  localparam logic [DayW-1:0] EPOCH_OFS = 16'd731;  // 1968-01-01 to 1970-01-01
  localparam logic [YearW-1:0] BASE_YEAR = 12'd1968;
  localparam logic [DayW-1:0] MAR31_INDEX = 16'd89;
  localparam logic [DayW-1:0] OCT31_INDEX = 16'd303;
  localparam logic [DayW-1:0] WDAY_OFS    = 16'd4;   // epoch day was a Thursday

  typedef struct packed {
    logic [SecsW-1:0] secs;
    logic [DayW-1:0]  days;
  } esd_days_t;

  // (v) mod 7 for a 16-bit value, using 8 == 1 (mod 7)
  function automatic logic [2:0] mod7(input logic [DayW-1:0] v);
    logic [5:0] s;
    logic [3:0] f;
    logic [3:0] r;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
      + 6'(v[15]);
    f = 4'(s[5:3]) + 4'(s[2:0]);
    r = (f >= 4'd7) ? f - 4'd7 : f;
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

### design/esd_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_days: seconds to day number
// Three-stage reciprocal divide of the saturated seconds count by 86400.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_days (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [esd_pkg::SecsW-1:0]     secs_i,
  output logic                               valid_o,
  output esd_pkg::esd_days_t                 res_o
);

  logic [2:0] vld_q;

  // stage 1: saturate, estimate quotient
  logic [esd_pkg::SecsW-1:0] t_sat;
  logic [47:0]               p1;
  logic [esd_pkg::SecsW-1:0] t1_q;
  logic [esd_pkg::DayW-1:0]  q1_q;

  assign t_sat = (secs_i > esd_pkg::LAST_SECOND) ? esd_pkg::LAST_SECOND : secs_i;
  assign p1    = 48'(t_sat[31:7]) * 48'(esd_pkg::DAY_RECIP);

  // stage 2: back-multiply
  logic [32:0]               prod2;
  logic [esd_pkg::SecsW-1:0] t2_q;
  logic [esd_pkg::DayW-1:0]  q2_q;
  logic [esd_pkg::SecsW-1:0] pr2_q;

  assign prod2 = 33'(q1_q) * 33'(esd_pkg::SECS_PER_DAY);

  // stage 3: remainder check and correction
  logic [esd_pkg::SecsW-1:0] rem3;
  logic [esd_pkg::DayW-1:0]  days3;
  logic [esd_pkg::SecsW-1:0] t3_q;
  logic [esd_pkg::DayW-1:0]  d3_q;

  assign rem3  = t2_q - pr2_q;
  assign days3 = (rem3 >= 32'(esd_pkg::SECS_PER_DAY)) ? q2_q + 16'd1 : q2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t_sat;
      q1_q  <= p1[47:32];
      t2_q  <= t1_q;
      q2_q  <= q1_q;
      pr2_q <= prod2[31:0];
      t3_q  <= t2_q;
      d3_q  <= days3;
    end
  end

  assign valid_o     = vld_q[2];
  assign res_o.secs  = t3_q;
  assign res_o.days  = d3_q;

endmodule

`default_nettype wire

### design/eu_summer_time_decider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eu_summer_time_decider: EU summer time check
// Finds the year of a seconds count, the last Sundays of March and October
// in that year, and whether the count lies between them.
//
//   channel  dir  signals                      item
//   s_axis   in   tvalid tready tdata[31:0]    seconds since 1970
//   m_axis   out  tvalid tready tdata[79:0]    flag, year, start, end
//
// Nine register stages, one item per cycle sustained while the output is not stalled.
// The whole pipeline advances together when the output register is empty
// or taken; a stall freezes every stage, so nothing is lost or repeated.
// Reset clears the valid bits only. Inputs past 2099-12-31 23:59:59 saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module eu_summer_time_decider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata    // [0] is_summer, [12:1] calendar_year,
                                           // [44:13] summer_start, [76:45] summer_end
);

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic               v3;
  esd_pkg::esd_days_t r3;

  esd_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .secs_i  (s_axis_tdata),
    .valid_o (v3),
    .res_o   (r3)
  );

  logic [5:0] vld_q;  // stages 4..9

  // stage 4: four-year cycle estimate
  logic [esd_pkg::DayW-1:0]  d4;
  logic [31:0]               p4;
  logic [31:0]               t4_q;
  logic [esd_pkg::DayW-1:0]  d4_q;
  logic [5:0]                c4_q;

  assign d4 = r3.days + esd_pkg::EPOCH_OFS;
  assign p4 = 32'(d4) * 32'(esd_pkg::CYCLE_RECIP);

  // stage 5: cycle remainder and correction
  logic [16:0] m5;
  logic [16:0] e5;
  logic [5:0]  c5;
  logic [10:0] e5c;
  logic [31:0] t5_q;
  logic [5:0]  c5_q;
  logic [10:0] e5_q;

  assign m5 = 17'(c4_q) * 17'(esd_pkg::CYCLE_DAYS);
  assign e5 = 17'(d4_q) - m5;
  always_comb begin
    if (e5 >= 17'(esd_pkg::CYCLE_DAYS)) begin
      c5  = c4_q + 6'd1;
      e5c = 11'(e5 - 17'(esd_pkg::CYCLE_DAYS));
    end else begin
      c5  = c4_q;
      e5c = e5[10:0];
    end
  end

  // stage 6: year within cycle, year start, month-end day numbers
  logic [1:0]                yo6;
  logic [10:0]               cum6;
  logic [16:0]               ys6;
  logic                      leap6;
  logic [esd_pkg::YearW-1:0] year6;
  logic [31:0]               t6_q;
  logic [esd_pkg::YearW-1:0] y6_q;
  logic [esd_pkg::DayW-1:0]  mar6_q;
  logic [esd_pkg::DayW-1:0]  oct6_q;

  always_comb begin
    priority if (e5_q < 11'd366) begin
      yo6 = 2'd0; cum6 = 11'd0;
    end else if (e5_q < 11'd731) begin
      yo6 = 2'd1; cum6 = 11'd366;
    end else if (e5_q < 11'd1096) begin
      yo6 = 2'd2; cum6 = 11'd731;
    end else begin
      yo6 = 2'd3; cum6 = 11'd1096;
    end
  end

  assign leap6 = (yo6 == 2'd0);
  assign ys6   = 17'(c5_q) * 17'(esd_pkg::CYCLE_DAYS) + 17'(cum6)
               - 17'(esd_pkg::EPOCH_OFS);
  assign year6 = esd_pkg::BASE_YEAR + {4'd0, c5_q, 2'b00} + 12'(yo6);

  // stage 7: step back to Sunday
  logic [esd_pkg::DayW-1:0]  msun7;
  logic [esd_pkg::DayW-1:0]  osun7;
  logic [31:0]               t7_q;
  logic [esd_pkg::YearW-1:0] y7_q;
  logic [esd_pkg::DayW-1:0]  ms7_q;
  logic [esd_pkg::DayW-1:0]  os7_q;

  assign msun7 = mar6_q - 16'(esd_pkg::mod7(mar6_q + esd_pkg::WDAY_OFS));
  assign osun7 = oct6_q - 16'(esd_pkg::mod7(oct6_q + esd_pkg::WDAY_OFS));

  // stage 8: day numbers to seconds
  logic [32:0]               st8;
  logic [32:0]               en8;
  logic [31:0]               t8_q;
  logic [esd_pkg::YearW-1:0] y8_q;
  logic [31:0]               st8_q;
  logic [31:0]               en8_q;

  assign st8 = 33'(ms7_q) * 33'(esd_pkg::SECS_PER_DAY) + 33'(esd_pkg::START_SECS);
  assign en8 = 33'(os7_q) * 33'(esd_pkg::SECS_PER_DAY) + 33'(esd_pkg::END_SECS);

  // stage 9: compare into the output register
  logic                      sum9_q;
  logic [esd_pkg::YearW-1:0] y9_q;
  logic [31:0]               st9_q;
  logic [31:0]               en9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], v3};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_q   <= r3.secs;
      d4_q   <= d4;
      c4_q   <= p4[esd_pkg::CycleShift +: 6];
      t5_q   <= t4_q;
      c5_q   <= c5;
      e5_q   <= e5c;
      t6_q   <= t5_q;
      y6_q   <= year6;
      mar6_q <= ys6[15:0] + esd_pkg::MAR31_INDEX + 16'(leap6);
      oct6_q <= ys6[15:0] + esd_pkg::OCT31_INDEX + 16'(leap6);
      t7_q   <= t6_q;
      y7_q   <= y6_q;
      ms7_q  <= msun7;
      os7_q  <= osun7;
      t8_q   <= t7_q;
      y8_q   <= y7_q;
      st8_q  <= st8[31:0];
      en8_q  <= en8[31:0];
      sum9_q <= (t8_q >= st8_q) && (t8_q <= en8_q);
      y9_q   <= y8_q;
      st9_q  <= st8_q;
      en9_q  <= en8_q;
    end
  end

  assign m_axis_tvalid = vld_q[5];
  assign m_axis_tdata  = {3'd0, en9_q, st9_q, y9_q, sum9_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (y9_q >= 12'd1970) && (y9_q <= 12'd2099))
    else $error("year out of range");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (en9_q - st9_q == 32'd18143999) ||
                      (en9_q - st9_q == 32'd18748799))
    else $error("summer span is not 30 or 31 weeks");

  a_start_sunday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> esd_pkg::mod7(ms7_q + esd_pkg::WDAY_OFS) == 3'd0)
    else $error("start day is not a Sunday");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(t8_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
